[sv/lzo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZO1X decompressor package
// Types, constants and codes shared by the decompressor modules.
// ----------------------------------------------------------------------------
package lzo_pkg;

	localparam int WindowBits = 16;
	localparam int MaxBurst   = 64;
	localparam int LengthBits = 24;
	localparam int BwBits     = 17;
	localparam int BurstBits  = $clog2(MaxBurst + 1);

	localparam logic [1:0] OP_BYTE   = 2'd0;
	localparam logic [1:0] OP_DRAIN  = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DISTANCE = 2'd1;
	localparam logic [1:0] ST_LENGTH   = 2'd2;
	localparam logic [1:0] ST_REFUSED  = 2'd3;

	typedef enum logic [3:0] {
		PH_HEADER, PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_MATCH_EXT,
		PH_OFF1, PH_OFF2, PH_COPY, PH_TRAIL, PH_DONE, PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		CTX_NORMAL, CTX_AFTER_LIT, CTX_AFTER_MATCH, CTX_FIRST
	} ctx_t;

	typedef enum logic [1:0] {
		SQ_IDLE, SQ_COPY, SQ_EMIT
	} seq_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       last;
		logic       copy_pending;
		logic       stream_done;
		logic [1:0] status;
	} out_item_t;

endpackage
`default_nettype wire

[sv/lzo_history.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZO history ring
// Single-port byte memory holding the decompressed window, registered read.
// ----------------------------------------------------------------------------
module lzo_history
	import lzo_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [WindowBits-1:0] addr,
	input  wire logic [7:0]            wr_data,
	output logic      [7:0]            rd_data
);

	logic [7:0] mem [0:(1 << WindowBits)-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end

endmodule
`default_nettype wire

[sv/lzo1x_stream_decompressor_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZO1X stream decompressor
// Token parser with a 64 KiB history ring; emits decompressed bytes.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | sink      | operation, data_byte
//  out     | source    | out_byte, out_valid, last, copy_pending, stream_done, status
//  cfg     | write     | header_skip
// An item with a single result passes through parse, load of the result
// register and transfer before the next item is accepted. A match copies each
// byte by a read then a write of the single-port history ring, up to 64 bytes
// per item, and output stalls hold the write. in_stall is high from acceptance
// until the last result of the item has been transferred, and output stalls
// lengthen this. Reset is asynchronous; the history ring is not cleared.
module lzo1x_stream_decompressor_top
	import lzo_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	seq_t seq_q, seq_d;
	phase_t phase_q, phase_d;
	ctx_t ctx_q, ctx_d;
	logic [7:0] header_skip_q, header_left_q, header_left_d;
	logic [7:0] token_q, token_d, off1_q, off1_d;
	logic [LengthBits:0] run_q, run_d;
	logic [LengthBits-1:0] copy_rem_q, copy_rem_d;
	logic [WindowBits-1:0] wr_idx_q, wr_idx_d, src_q, src_d;
	logic [BwBits-1:0] bw_q, bw_d;
	logic [1:0] trail_q, trail_d, err_q, err_d;
	logic done_q, done_d;
	logic [BurstBits-1:0] burst_q, burst_d;
	logic rd_phase_q, rd_phase_d;
	logic emit_pend_q, emit_pend_d;
	logic [7:0] emit_byte_q, emit_byte_d;
	logic ov_q, ov_d;
	out_item_t od_q, od_d;

	logic mem_we;
	logic [WindowBits-1:0] mem_addr;
	logic [7:0] mem_wdata, mem_rdata;

	lzo_history u_hist (
		.clk(clk), .wr_en(mem_we), .addr(mem_addr),
		.wr_data(mem_wdata), .rd_data(mem_rdata)
	);

	logic acc;
	assign acc = in_valid && !in_stall;
	assign in_stall = (seq_q != SQ_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign out_data = od_q;

	// Shared match-setup arithmetic, driven by the parser.
	logic [17:0] match_dist;
	logic [LengthBits:0] mlen;
	logic [1:0] mtrail;
	logic start_m;

	always_comb begin
		logic [7:0] b;
		logic [17:0] d;
		b = in_data.data_byte;
		seq_d = seq_q; phase_d = phase_q; ctx_d = ctx_q;
		header_left_d = header_left_q; token_d = token_q; off1_d = off1_q;
		run_d = run_q; copy_rem_d = copy_rem_q; wr_idx_d = wr_idx_q;
		src_d = src_q; bw_d = bw_q; trail_d = trail_q; err_d = err_q;
		done_d = done_q; burst_d = burst_q; rd_phase_d = rd_phase_q;
		emit_pend_d = 1'b0; emit_byte_d = emit_byte_q;
		ov_d = ov_q; od_d = od_q;
		match_dist = '0; mlen = '0; mtrail = '0; start_m = 1'b0; d = '0;
		mem_we = 1'b0; mem_addr = src_q; mem_wdata = emit_byte_q;

		if (ov_q && !out_stall) ov_d = 1'b0;

		// Pending single write of an emitted parser byte.
		if (emit_pend_q) begin
			mem_we = 1'b1; mem_addr = wr_idx_q; mem_wdata = emit_byte_q;
			wr_idx_d = wr_idx_q + 1'b1;
			if (bw_q != '1) bw_d = bw_q + 1'b1;
		end

		unique case (seq_q)
			SQ_IDLE: begin
				if (acc) begin
					unique case (in_data.operation)
						OP_BYTE: begin
							unique case (phase_q)
								PH_HEADER, PH_TOKEN: begin
									if (phase_q == PH_HEADER && header_left_q != 0) begin
										header_left_d = header_left_q - 1'b1;
									end else begin
										token_d = b;
										if ((phase_q == PH_HEADER || ctx_q == CTX_FIRST) && b > 8'd17) begin
											if (b - 8'd17 < 8'd4) begin
												trail_d = 2'(b - 8'd17); phase_d = PH_TRAIL;
											end else begin
												run_d = (LengthBits+1)'(b - 8'd17);
												phase_d = PH_LITERALS;
											end
										end else if (b >= 8'd64) phase_d = PH_OFF1;
										else if (b >= 8'd16) begin
											run_d = (LengthBits+1)'(b >= 8'd32 ? (b & 8'd31) : (b & 8'd7));
											phase_d = (run_d == 0) ? PH_MATCH_EXT : PH_OFF1;
										end else if (phase_q == PH_TOKEN &&
											(ctx_q == CTX_AFTER_LIT || ctx_q == CTX_AFTER_MATCH))
											phase_d = PH_OFF1;
										else if (b == 0) begin
											run_d = '0; phase_d = PH_LIT_EXT;
										end else begin
											run_d = (LengthBits+1)'(b + 9'd3); phase_d = PH_LITERALS;
										end
										if (phase_q == PH_HEADER) ctx_d = CTX_FIRST;
									end
								end
								PH_LIT_EXT, PH_MATCH_EXT: begin
									if (b == 0) run_d = run_q + (LengthBits+1)'(255);
									else if (phase_q == PH_LIT_EXT)
										run_d = run_q + (LengthBits+1)'(b + 9'd18);
									else run_d = run_q +
										(LengthBits+1)'(b + (token_q >= 8'd32 ? 9'd31 : 9'd7));
									if (run_d[LengthBits]) begin
										if (err_q == ST_OK) err_d = ST_LENGTH;
										phase_d = PH_ERROR;
									end else if (b != 0)
										phase_d = (phase_q == PH_LIT_EXT) ? PH_LITERALS : PH_OFF1;
								end
								PH_LITERALS, PH_TRAIL: begin
									emit_pend_d = 1'b1; emit_byte_d = b;
									if (phase_q == PH_LITERALS) begin
										if (run_q != 0) run_d = run_q - 1'b1;
										if (run_d == 0) begin
											phase_d = PH_TOKEN; ctx_d = CTX_AFTER_LIT;
										end
									end else begin
										if (trail_q != 0) trail_d = trail_q - 1'b1;
										if (trail_d == 0) begin
											phase_d = PH_TOKEN; ctx_d = CTX_AFTER_MATCH;
										end
									end
								end
								PH_OFF1: begin
									if (token_q < 8'd16) begin
										match_dist = 18'd1 + 18'(token_q >> 2) + (18'(b) << 2);
										if (ctx_q == CTX_AFTER_LIT) begin
											match_dist = match_dist + 18'h0800;
											mlen = (LengthBits+1)'(3);
										end else mlen = (LengthBits+1)'(2);
										mtrail = token_q[1:0]; start_m = 1'b1;
									end else if (token_q >= 8'd64) begin
										match_dist = 18'd1 + 18'(token_q[4:2]) + (18'(b) << 3);
										mlen = (LengthBits+1)'(token_q[7:5] + 4'd1);
										mtrail = token_q[1:0]; start_m = 1'b1;
									end else begin
										off1_d = b; phase_d = PH_OFF2;
									end
								end
								PH_OFF2: begin
									d = 18'(off1_q >> 2) + (18'(b) << 6);
									mlen = run_q + (LengthBits+1)'(2); mtrail = off1_q[1:0];
									if (token_q >= 8'd32) begin
										match_dist = d + 1'b1; start_m = 1'b1;
									end else if (!token_q[3] && d == 0) begin
										done_d = 1'b1; phase_d = PH_DONE;
									end else begin
										match_dist = d + (18'(token_q[3]) << 14) + 18'h4000;
										start_m = 1'b1;
									end
								end
								PH_COPY, PH_DONE: begin
									if (err_q == ST_OK) err_d = ST_REFUSED;
									copy_rem_d = '0; phase_d = PH_ERROR;
								end
								default: ;
							endcase
							if (start_m) begin
								if (mlen[LengthBits]) begin
									if (err_q == ST_OK) err_d = ST_LENGTH;
									phase_d = PH_ERROR;
								end else if (match_dist > 18'(bw_q) ||
									match_dist > 18'(1 << WindowBits)) begin
									if (err_q == ST_OK) err_d = ST_DISTANCE;
									phase_d = PH_ERROR;
								end else begin
									src_d = wr_idx_q - match_dist[WindowBits-1:0];
									copy_rem_d = mlen[LengthBits-1:0];
									trail_d = mtrail; phase_d = PH_COPY;
									seq_d = SQ_COPY; burst_d = '0; rd_phase_d = 1'b0;
								end
							end
							if (seq_d == SQ_IDLE) seq_d = SQ_EMIT;
						end
						OP_DRAIN: begin
							if (phase_q == PH_COPY) begin
								seq_d = SQ_COPY; burst_d = '0; rd_phase_d = 1'b0;
							end else seq_d = SQ_EMIT;
						end
						OP_START: begin
							wr_idx_d = '0; bw_d = '0; phase_d = PH_HEADER; ctx_d = CTX_FIRST;
							header_left_d = header_skip_q; token_d = '0; off1_d = '0;
							run_d = '0; copy_rem_d = '0; src_d = '0; trail_d = '0;
							done_d = 1'b0; err_d = ST_OK; seq_d = SQ_EMIT;
						end
						default: seq_d = SQ_EMIT;
					endcase
				end
			end
			SQ_EMIT: begin
				// Single result: either the parser byte or an empty item.
				if (!ov_q || !out_stall) begin
					ov_d = 1'b1;
					od_d.out_byte = emit_pend_q ? emit_byte_q : 8'd0;
					od_d.out_valid = emit_pend_q;
					od_d.last = 1'b1;
					od_d.copy_pending = (phase_q == PH_COPY);
					od_d.stream_done = done_q;
					od_d.status = err_q;
					seq_d = SQ_IDLE;
				end else emit_pend_d = emit_pend_q;
				if (emit_pend_q && ov_q && out_stall) begin
					// Write again when the result is finally sent.
					mem_we = 1'b0; wr_idx_d = wr_idx_q; bw_d = bw_q;
				end
			end
			SQ_COPY: begin
				if (!rd_phase_q) begin
					mem_addr = src_q; rd_phase_d = 1'b1;
				end else if (!ov_q || !out_stall) begin
					mem_we = 1'b1; mem_addr = wr_idx_q; mem_wdata = mem_rdata;
					wr_idx_d = wr_idx_q + 1'b1;
					if (bw_q != '1) bw_d = bw_q + 1'b1;
					src_d = src_q + 1'b1;
					copy_rem_d = copy_rem_q - 1'b1;
					burst_d = burst_q + 1'b1;
					rd_phase_d = 1'b0;
					if (copy_rem_d == 0) begin
						if (trail_q == 0) begin
							phase_d = PH_TOKEN; ctx_d = CTX_NORMAL;
						end else phase_d = PH_TRAIL;
					end
					ov_d = 1'b1;
					od_d.out_byte = mem_rdata; od_d.out_valid = 1'b1;
					od_d.last = (copy_rem_d == 0) || (burst_d == BurstBits'(MaxBurst));
					// Every result of the burst reports whether bytes remain after the burst ends.
					od_d.copy_pending =
						(copy_rem_q > LengthBits'(BurstBits'(MaxBurst) - burst_q));
					od_d.stream_done = done_q; od_d.status = err_q;
					if (od_d.last) seq_d = SQ_IDLE;
				end
			end
			default: seq_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE; phase_q <= PH_HEADER; ctx_q <= CTX_FIRST;
			header_skip_q <= 8'd8; header_left_q <= 8'd8; token_q <= '0; off1_q <= '0;
			run_q <= '0; copy_rem_q <= '0; wr_idx_q <= '0; src_q <= '0; bw_q <= '0;
			trail_q <= '0; err_q <= ST_OK; done_q <= 1'b0; burst_q <= '0;
			rd_phase_q <= 1'b0; emit_pend_q <= 1'b0; emit_byte_q <= '0; ov_q <= 1'b0;
			od_q <= '0;
		end else begin
			seq_q <= seq_d; phase_q <= phase_d; ctx_q <= ctx_d;
			if (cfg_we) header_skip_q <= cfg_wdata;
			header_left_q <= header_left_d; token_q <= token_d; off1_q <= off1_d;
			run_q <= run_d; copy_rem_q <= copy_rem_d; wr_idx_q <= wr_idx_d;
			src_q <= src_d; bw_q <= bw_d; trail_q <= trail_d; err_q <= err_d;
			done_q <= done_d; burst_q <= burst_d; rd_phase_q <= rd_phase_d;
			emit_pend_q <= emit_pend_d; emit_byte_q <= emit_byte_d; ov_q <= ov_d;
			od_q <= od_d;
		end
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != SQ_IDLE) |-> in_stall) else $error("input taken while busy");
	a_copy_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.copy_pending) |-> out_data.status == ST_OK)
		else $error("copy pending with error");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q <= BurstBits'(MaxBurst)) else $error("burst overrun");
`endif

endmodule
`default_nettype wire
